// File: rtl/core/clne_pkg.sv
// Shared types, codes and constants for the color line number extractor.
`default_nettype none

package clne_pkg;

  // Scan mode codes
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_HASH = 2'd2;

  // Command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Saturation ceiling of a number
  localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

  // Digit count ceiling, the two hash token shapes and the number count ceiling
  localparam logic [2:0] DIGIT_CNT_MAX = 3'd7;
  localparam logic [2:0] HASH_SHORT    = 3'd3;
  localparam logic [2:0] HASH_LONG     = 3'd6;
  localparam logic [1:0] NUM_CNT_MAX   = 2'd3;

  // Characters of interest
  localparam logic [15:0] CHAR_LF    = 16'd10;
  localparam logic [15:0] CHAR_CR    = 16'd13;
  localparam logic [15:0] CHAR_TAB   = 16'd9;
  localparam logic [15:0] CHAR_SPACE = 16'd32;
  localparam logic [15:0] CHAR_HASH  = 16'd35;
  localparam logic [15:0] CHAR_0     = 16'd48;
  localparam logic [15:0] CHAR_9     = 16'd57;
  localparam logic [15:0] CHAR_UA    = 16'd65;
  localparam logic [15:0] CHAR_UF    = 16'd70;
  localparam logic [15:0] CHAR_UX    = 16'd88;
  localparam logic [15:0] CHAR_LA    = 16'd97;
  localparam logic [15:0] CHAR_LF_HEX = 16'd102;
  localparam logic [15:0] CHAR_LX    = 16'd120;

  // Classification of one item
  typedef struct packed {
    logic       line_end;   // carriage return or end of text
    logic       skip;       // line feed, no effect
    logic       dec_digit;
    logic       hex_digit;
    logic [3:0] digit_val;
    logic       is_x;
    logic       is_hash;
    logic       is_blank;
  } char_class_t;

  // Per-line scan state
  typedef struct packed {
    logic [1:0]  scan_mode;
    logic        hex_flag;
    logic [31:0] accumulator;
    logic        saturated;
    logic [2:0]  digit_count;
    logic [1:0]  number_count;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic        text_seen;
  } scan_state_t;

  // One RGB result
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       named;
  } rgb_result_t;

  localparam scan_state_t SCAN_RESET = '{
    scan_mode:    MODE_TEXT,
    hex_flag:     1'b0,
    accumulator:  32'd0,
    saturated:    1'b0,
    digit_count:  3'd0,
    number_count: 2'd0,
    chan0:        8'd0,
    chan1:        8'd0,
    chan2:        8'd0,
    text_seen:    1'b0
  };

endpackage

`default_nettype wire

// File: rtl/core/clne_char_class.sv
// Character decoder: sorts one item into digit, marker, blank, line-feed and line-end classes.
`default_nettype none

module clne_char_class (
  input  wire logic                 cmd,
  input  wire logic [15:0]          ch,
  output clne_pkg::char_class_t     cls
);
  import clne_pkg::*;

  logic        end_of_text;
  logic        is_cr;
  logic        is_dec;
  logic        is_upper;
  logic        is_lower;
  logic [15:0] dec_off;
  logic [15:0] upper_off;
  logic [15:0] lower_off;

  // Range checks on the raw code unit
  assign end_of_text = (cmd == CMD_END);
  assign is_cr       = (ch == CHAR_CR);
  assign is_dec      = (ch >= CHAR_0)  && (ch <= CHAR_9);
  assign is_upper    = (ch >= CHAR_UA) && (ch <= CHAR_UF);
  assign is_lower    = (ch >= CHAR_LA) && (ch <= CHAR_LF_HEX);
  assign dec_off     = ch - CHAR_0;
  assign upper_off   = ch - CHAR_UA + 16'd10;
  assign lower_off   = ch - CHAR_LA + 16'd10;

  // Line end acts as a space; the character is ignored then
  always_comb begin
    cls           = '0;
    cls.line_end  = end_of_text || is_cr;
    if (end_of_text || is_cr) begin
      cls.is_blank = 1'b1;
    end else begin
      cls.skip      = (ch == CHAR_LF);
      cls.dec_digit = is_dec;
      cls.hex_digit = is_dec || is_upper || is_lower;
      if (is_dec) begin
        cls.digit_val = dec_off[3:0];
      end else if (is_upper) begin
        cls.digit_val = upper_off[3:0];
      end else begin
        cls.digit_val = lower_off[3:0];
      end
      cls.is_x     = (ch == CHAR_UX) || (ch == CHAR_LX);
      cls.is_hash  = (ch == CHAR_HASH);
      cls.is_blank = (ch == CHAR_SPACE) || (ch == CHAR_TAB);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/clne_scan_update.sv
// Scan step: next line state and the RGB result for one classified item.
`default_nettype none

module clne_scan_update (
  input  wire clne_pkg::scan_state_t  state,
  input  wire clne_pkg::char_class_t  cls,
  output clne_pkg::scan_state_t       state_next,
  output logic                        emit,
  output clne_pkg::rgb_result_t       result
);
  import clne_pkg::*;

  logic        base16;
  logic [35:0] prod;
  logic [35:0] sum;
  logic [31:0] acc_new;
  logic        sat_new;
  logic        do_push;
  logic        push_three;
  logic [7:0]  pv0;
  logic [7:0]  pv1;
  logic [7:0]  pv2;
  scan_state_t fed;

  // Multiply-add by the token base with saturation
  assign base16 = (state.scan_mode == MODE_HASH) || state.hex_flag;
  assign prod   = base16 ? {state.accumulator, 4'b0000}
                         : ({1'b0, state.accumulator, 3'b000} + {3'b000, state.accumulator, 1'b0});
  assign sum    = prod + {32'd0, cls.digit_val};

  always_comb begin
    if (state.saturated) begin
      acc_new = state.accumulator;
      sat_new = 1'b1;
    end else if (sum > {4'd0, VALUE_MAX}) begin
      acc_new = VALUE_MAX;
      sat_new = 1'b1;
    end else begin
      acc_new = sum[31:0];
      sat_new = 1'b0;
    end
  end

  // Feed the character through the scanner
  always_comb begin
    fed        = state;
    do_push    = 1'b0;
    push_three = 1'b0;
    pv0        = state.accumulator[7:0];
    pv1        = 8'd0;
    pv2        = 8'd0;
    case (state.scan_mode)
      MODE_HASH: begin
        if (cls.hex_digit) begin
          fed.accumulator = acc_new;
          fed.saturated   = sat_new;
          if (state.digit_count < DIGIT_CNT_MAX) begin
            fed.digit_count = state.digit_count + 3'd1;
          end
        end else begin
          do_push       = 1'b1;
          fed.scan_mode = MODE_TEXT;
          if (state.digit_count == HASH_SHORT) begin
            push_three = 1'b1;
            pv0 = {state.accumulator[11:8], 4'h0};
            pv1 = {state.accumulator[7:4], 4'h0};
            pv2 = {state.accumulator[3:0], 4'h0};
          end else if (state.digit_count == HASH_LONG) begin
            push_three = 1'b1;
            pv0 = state.accumulator[23:16];
            pv1 = state.accumulator[15:8];
            pv2 = state.accumulator[7:0];
          end
        end
      end
      MODE_NUM: begin
        if (cls.is_x && !state.hex_flag) begin
          fed.hex_flag    = 1'b1;
          fed.accumulator = 32'd0;
          fed.saturated   = 1'b0;
        end else if (state.hex_flag ? cls.hex_digit : cls.dec_digit) begin
          fed.accumulator = acc_new;
          fed.saturated   = sat_new;
        end else begin
          do_push       = 1'b1;
          fed.scan_mode = MODE_TEXT;
        end
      end
      default: begin
        if (cls.dec_digit) begin
          fed.hex_flag    = 1'b0;
          fed.scan_mode   = MODE_NUM;
          fed.accumulator = {28'd0, cls.digit_val};
          fed.saturated   = 1'b0;
          fed.digit_count = 3'd0;
        end else if (cls.is_hash) begin
          fed.scan_mode   = MODE_HASH;
          fed.accumulator = 32'd0;
          fed.saturated   = 1'b0;
          fed.digit_count = 3'd0;
        end else if (!cls.is_blank) begin
          fed.text_seen = 1'b1;
        end
      end
    endcase

    // Store pushed numbers into the free channel slots
    if (do_push) begin
      case (state.number_count)
        2'd0: begin
          fed.chan0 = pv0;
          if (push_three) begin
            fed.chan1 = pv1;
            fed.chan2 = pv2;
          end
        end
        2'd1: begin
          fed.chan1 = pv0;
          if (push_three) begin
            fed.chan2 = pv1;
          end
        end
        2'd2: fed.chan2 = pv0;
        default: ;
      endcase
      if (push_three || state.number_count == 2'd2) begin
        fed.number_count = NUM_CNT_MAX;
      end else if (state.number_count != NUM_CNT_MAX) begin
        fed.number_count = state.number_count + 2'd1;
      end
    end
  end

  // Decide on the result at line end, then clear the line
  always_comb begin
    result.red   = fed.chan0;
    result.green = fed.chan1;
    result.blue  = fed.chan2;
    result.named = fed.text_seen;
    emit         = 1'b0;
    if (cls.line_end) begin
      emit       = fed.text_seen || (fed.number_count != 2'd0);
      state_next = SCAN_RESET;
    end else if (cls.skip) begin
      state_next = state;
    end else begin
      state_next = fed;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/color_line_number_extractor_unit.sv
// Top level of the color line number extractor: input register, scan state, result register.
`default_nettype none

// Takes one text character (or end-of-text command) per clock and emits one RGB result
// at each line end that carried label text or numbers. An item is registered on
// transfer and its scan step runs in the following cycle; any result is loaded into
// the result register when the item is consumed, so the input register and the result
// register lie between an input transfer and the result transferring out.
// A new item transfers every cycle; the input only stalls while the held item ends a
// line with a result and the result register is still full and stalled.
module color_line_number_extractor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        cmd,
  input  wire logic [15:0] ch,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             named
);
  import clne_pkg::*;

  logic        q_valid;
  logic        q_cmd;
  logic [15:0] q_ch;
  char_class_t cls;
  scan_state_t state;
  scan_state_t state_next;
  logic        emit;
  rgb_result_t result;
  logic        consume;
  logic        blocked;

  clne_char_class u_class (
    .cmd (q_cmd),
    .ch  (q_ch),
    .cls (cls)
  );

  clne_scan_update u_update (
    .state      (state),
    .cls        (cls),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  // Hold the item only when its result cannot enter the result register
  assign blocked    = emit && result_valid && result_stall;
  assign consume    = q_valid && !blocked;
  assign item_stall = q_valid && blocked;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!item_stall) begin
      q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      q_cmd <= cmd;
      q_ch  <= ch;
    end
  end

  // Advance the scan state on each consumed item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_RESET;
    end else if (consume) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (consume && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      red   <= result.red;
      green <= result.green;
      blue  <= result.blue;
      named <= result.named;
    end
  end

endmodule

`default_nettype wire
